// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// ===== hw/rtl/fcsl_pkg.sv =====
package fcsl_pkg;
  localparam int unsigned MaxNodes = 32;
  localparam int unsigned AddrW = $clog2(MaxNodes);
  localparam int unsigned CountW = AddrW + 1;
  localparam int unsigned SumW = 38;

  typedef struct packed {
    logic signed [31:0] node_value;
    logic signed [31:0] bound_low;
    logic signed [31:0] bound_high;
    logic [30:0]        diffusion_sum;
    logic signed [31:0] raw_flux;
    logic               final_node;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] limited_flux;
    logic               last_of_element;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ratio;
  } scale_t;

  localparam logic [1:0] ModePass = 2'd0;
  localparam logic [1:0] ModePos = 2'd1;
  localparam logic [1:0] ModeNeg = 2'd2;
endpackage

// ===== hw/rtl/fcsl_in_if.sv =====
interface fcsl_in_if;
  logic valid;
  logic ready;
  fcsl_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/fcsl_out_if.sv =====
interface fcsl_out_if;
  logic valid;
  logic ready;
  fcsl_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/fcsl_bound_mul.sv =====
module fcsl_bound_mul (
  input  logic [31:0]        g2_i,
  input  logic signed [32:0] diff_i,
  output logic signed [31:0] flux_o
);
  import fcsl_pkg::*;
  logic        neg;
  logic [32:0] mag;
  logic [64:0] prod;
  logic [48:0] shr;
  assign neg = diff_i[32];
  assign mag = neg ? 33'(-diff_i) : 33'(diff_i);
  assign prod = 65'(g2_i) * 65'(mag);
  assign shr = prod[64:16];
  always_comb begin
    if (neg) begin
      flux_o = (shr > 49'h80000000) ? 32'sh80000000 : 32'(-shr);
    end else begin
      flux_o = (shr > 49'h7FFFFFFF) ? 32'sh7FFFFFFF : shr[31:0];
    end
  end
endmodule

// ===== hw/rtl/fcsl_divider.sv =====
module fcsl_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fcsl_pkg::SumW-1:0]     num_i,
  input  logic [fcsl_pkg::SumW-1:0]     den_i,
  output logic                          done_o,
  output logic [31:0]                   quot_o
);
  import fcsl_pkg::*;
  logic [SumW:0]   rem_q, rem_d;
  logic [SumW-1:0] den_q, den_d;
  logic [31:0]     quot_q, quot_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SumW:0]   sh;

  assign sh = {rem_q[SumW-1:0], 1'b0};

  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    quot_d = quot_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = {1'b0, num_i};
      den_d = den_i;
      quot_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = sh;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ===== hw/rtl/fcsl_store.sv =====
module fcsl_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [fcsl_pkg::AddrW-1:0]   waddr_i,
  input  logic signed [31:0]           wdata_i,
  input  logic                         re_i,
  input  logic [fcsl_pkg::AddrW-1:0]   raddr_i,
  output logic signed [31:0]           rdata_o
);
  import fcsl_pkg::*;
  logic signed [31:0] mem [MaxNodes];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== hw/rtl/flux_clip_and_scale_limiter.sv =====
// Clip-and-scale flux limiter. Each accepted word loads one node of an element; the clipped
// flux goes into a 32-entry store. When the final node arrives (or the store fills), a
// 32-step restoring divider forms the scale ratio; it is skipped when the positive and
// negative sums cancel. Then the stored fluxes are read back and emitted in load order.
// Each stored word is read from the store and then loaded into the output register; no
// new read starts while one is pending, and stalls at the sink hold the reads. Inputs are
// not accepted from the close of an element until its last result has been taken.
`include "assert_macros.svh"
module flux_clip_and_scale_limiter (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcsl_in_if.sink    in_i,
  fcsl_out_if.source out_o
);
  import fcsl_pkg::*;

  typedef enum logic [1:0] {Load, Divide, Emit} state_e;

  state_e              state_q;
  logic [CountW-1:0]   count_q, rd_q;
  logic signed [SumW-1:0] pos_q, neg_q;
  scale_t              scale_q;
  logic                rd_pend_q, ov_q;
  out_word_t           ov_data_q;
  logic signed [SumW-1:0] total;
  logic                div_start, div_done;
  logic                div_busy_q;
  logic [31:0]         div_quot;
  logic [SumW-1:0]     div_num, div_den;
  logic signed [31:0]  fmin, fmax, clip, rdata;
  logic                acc, closing, rd_en, pend_last;
  logic [31:0]         g2, mag;
  logic [63:0]         sprod;
  logic signed [31:0]  scaled;
  logic [CountW-1:0]   count_inc;
  logic signed [SumW-1:0] pos_n, neg_n;

  assign g2 = {in_i.data.diffusion_sum, 1'b0};
  fcsl_bound_mul u_lo (.g2_i(g2),
    .diff_i(33'(in_i.data.bound_low) - 33'(in_i.data.node_value)), .flux_o(fmin));
  fcsl_bound_mul u_hi (.g2_i(g2),
    .diff_i(33'(in_i.data.bound_high) - 33'(in_i.data.node_value)), .flux_o(fmax));

  always_comb begin
    clip = in_i.data.raw_flux;
    if (clip < fmin) clip = fmin;
    if (clip > fmax) clip = fmax;
  end

  assign in_i.ready = (state_q == Load);
  assign acc = in_i.valid && in_i.ready;
  assign count_inc = count_q + 1'b1;
  assign closing = acc && (in_i.data.final_node || count_inc == CountW'(MaxNodes));

  assign pos_n = (clip > 0) ? pos_q + SumW'(clip) : pos_q;
  assign neg_n = (clip > 0) ? neg_q : neg_q + SumW'(clip);
  assign total = pos_q + neg_q;
  assign div_start = (state_q == Divide) && !rd_pend_q && scale_q.mode == ModePass
                     && !div_busy_q && total != 0;
  assign div_num = (total > 0) ? SumW'(-neg_q) : SumW'(pos_q);
  assign div_den = (total > 0) ? SumW'(pos_q) : SumW'(-neg_q);

  fcsl_divider u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quot_o(div_quot));

  // Read one entry when the output register will have room.
  assign rd_en = (state_q == Emit) && (rd_q != count_q) && !rd_pend_q
                 && (!ov_q || out_o.ready);
  fcsl_store u_store (.clk_i, .we_i(acc),
    .waddr_i(count_q[AddrW-1:0]), .wdata_i(clip), .re_i(rd_en),
    .raddr_i(rd_q[AddrW-1:0]), .rdata_o(rdata));

  assign mag = rdata[31] ? 32'(-rdata) : 32'(rdata);
  assign sprod = 64'(mag) * 64'(scale_q.ratio);
  always_comb begin
    scaled = rdata;
    if (scale_q.mode == ModePos && rdata > 0) scaled = 32'(sprod[63:32]);
    else if (scale_q.mode == ModeNeg && rdata < 0) scaled = 32'(-sprod[63:32]);
  end
  assign pend_last = (rd_q == count_q);

  assign out_o.valid = ov_q;
  assign out_o.data = ov_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Load;
      count_q <= '0;
      rd_q <= '0;
      pos_q <= '0;
      neg_q <= '0;
      scale_q <= '0;
      rd_pend_q <= 1'b0;
      ov_q <= 1'b0;
      ov_data_q <= '0;
      div_busy_q <= 1'b0;
    end else begin
      unique case (state_q)
        Load: begin
          if (acc) begin
            count_q <= count_inc;
            pos_q <= pos_n;
            neg_q <= neg_n;
            if (closing) state_q <= Divide;
          end
        end
        Divide: begin
          if (div_start) begin
            div_busy_q <= 1'b1;
          end else if (total == 0) begin
            scale_q.mode <= ModePass;
            state_q <= Emit;
          end else if (div_done) begin
            div_busy_q <= 1'b0;
            scale_q.mode <= (total > 0) ? ModePos : ModeNeg;
            scale_q.ratio <= div_quot;
            state_q <= Emit;
          end
        end
        Emit: begin
          if (rd_en) rd_q <= rd_q + 1'b1;
          rd_pend_q <= rd_en;
          if (ov_q && out_o.ready) begin
            ov_q <= 1'b0;
            if (ov_data_q.last_of_element) begin
              state_q <= Load;
              count_q <= '0;
              rd_q <= '0;
              pos_q <= '0;
              neg_q <= '0;
              scale_q.mode <= ModePass;
            end
          end
          if (rd_pend_q) begin
            ov_q <= 1'b1;
            ov_data_q.limited_flux <= scaled;
            ov_data_q.last_of_element <= pend_last;
          end
        end
        default: state_q <= Load;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_accept_emit, clk_i, rst_ni, acc && state_q == Emit, "input in emit")
  `ASSERT_IMPL(a_rd_bound, clk_i, rst_ni, rd_q <= count_q, "read past count")
  `ASSERT_IMPL(a_div_zero, clk_i, rst_ni, !div_start || div_den != 0, "divide by zero")
endmodule
